@@ rtl/core/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// mvt_pkg: shared types for the 4x4 matrix / 4-vector transform
// Word formats on the ports, the word carried along the cell chain, and the
// operation codes.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_LANES = 4;
    localparam int IDX_W     = 4;
    // Row sums: four products of 64 - FRAC_BITS bits each; wide enough for
    // the smallest supported fraction width (4).
    localparam int SUM_W     = 62;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_XFORM = 1'b1
    } func_t;

    typedef struct packed {
        func_t                    func;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] vec_w;
    } mvt_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
    } mvt_out_t;

    typedef logic [SUM_W-1:0] sum_t;

    // Word handed from cell to cell: the input word plus running row sums.
    typedef struct packed {
        logic                    valid;
        mvt_in_t                 item;
        sum_t [NUM_LANES-1:0]    sums;
    } mvt_word_t;

    // Vector component used by one column.
    function automatic logic signed [DATA_W-1:0] vec_comp(input mvt_in_t it,
                                                         input logic [1:0] c);
        logic signed [DATA_W-1:0] v;
        unique case (c)
            2'd0:    v = it.vec_x;
            2'd1:    v = it.vec_y;
            2'd2:    v = it.vec_z;
            default: v = it.vec_w;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/mvt_cell.sv @@
// ----------------------------------------------------------------------------
// mvt_cell: one column cell of the transform chain
// Holds one matrix column, multiplies it by its vector component and adds
// the shifted products into the row sums passing through. Two stages.
// ----------------------------------------------------------------------------
module mvt_cell #(
    parameter int FRAC_BITS = 16,
    parameter int COL       = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  mvt_pkg::mvt_word_t in_word,
    output mvt_pkg::mvt_word_t out_word
);
    import mvt_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0]   col_reg    [NUM_LANES];
    logic signed [2*DATA_W-1:0] prod_next  [NUM_LANES];
    logic signed [2*DATA_W-1:0] a_prod_reg [NUM_LANES];
    mvt_word_t                  a_word_reg;
    mvt_word_t                  b_word_reg;
    mvt_word_t                  b_word_next;
    logic signed [DATA_W-1:0]   vcomp;
    logic                       load_hit;

    assign vcomp    = vec_comp(in_word.item, 2'(COL));
    assign load_hit = adv && in_word.valid && (in_word.item.func == FUNC_LOAD) &&
                      (in_word.item.entry_index[IDX_W-1:2] == 2'(COL));

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            prod_next[r] = col_reg[r] * vcomp;
        end
    end

    // Shift (floor) and accumulate.
    always_comb begin
        b_word_next = a_word_reg;
        for (int r = 0; r < NUM_LANES; r++) begin
            b_word_next.sums[r] = a_word_reg.sums[r] +
                                  SUM_W'(a_prod_reg[r] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_LANES; r++) begin
                col_reg[r] <= (r == COL) ? ONE_Q : '0;
            end
            a_word_reg.valid <= 1'b0;
            b_word_reg.valid <= 1'b0;
        end else if (adv) begin
            if (load_hit) begin
                col_reg[in_word.item.entry_index[1:0]] <= in_word.item.entry_value;
            end
            a_word_reg <= in_word;
            a_prod_reg <= prod_next;
            b_word_reg <= b_word_next;
        end
    end

    assign out_word = b_word_reg;

endmodule

@@ rtl/core/mvt_out.sv @@
// ----------------------------------------------------------------------------
// mvt_out: saturation and output skid stage
// Saturates the row sums to 32 bits and holds results in an output register
// plus one skid word, so the chain keeps moving while a result waits.
// ----------------------------------------------------------------------------
module mvt_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  mvt_pkg::mvt_word_t tail_word,
    output logic               skid_full,
    output logic               m_valid,
    input  logic               m_ready,
    output mvt_pkg::mvt_out_t  m_data
);
    import mvt_pkg::*;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic                     res_valid;
    logic signed [DATA_W-1:0] sat [NUM_LANES];
    mvt_out_t                 res_data;
    logic                     m_valid_reg;
    mvt_out_t                 m_data_reg;
    logic                     skid_valid_reg;
    mvt_out_t                 skid_data_reg;

    function automatic logic signed [DATA_W-1:0] saturate(input sum_t s);
        logic signed [DATA_W-1:0] q;
        if (&s[SUM_W-1:DATA_W-1] || ~|s[SUM_W-1:DATA_W-1]) begin
            q = s[DATA_W-1:0];
        end else if (s[SUM_W-1]) begin
            q = Q_MIN;
        end else begin
            q = Q_MAX;
        end
        return q;
    endfunction

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            sat[r] = saturate(tail_word.sums[r]);
        end
        res_data.out_x = sat[0];
        res_data.out_y = sat[1];
        res_data.out_z = sat[2];
        res_data.out_w = sat[3];
    end

    assign res_valid = tail_word.valid && (tail_word.item.func == FUNC_XFORM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= res_valid;
                m_data_reg  <= res_data;
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
            end
        end else if (m_ready) begin
            m_data_reg     <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    assign skid_full = skid_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

@@ rtl/core/mat4_vec4_transform.sv @@
// ----------------------------------------------------------------------------
// mat4_vec4_transform: 4x4 matrix times 4-vector, signed Q16.16
// Load words write one matrix entry; transform words return M * v.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output skid word is free, loads and
// transforms mixed freely, and returns one result word per clock for
// transforms while the consumer is ready. The matrix lives in a chain of
// four column cells; every word walks the whole chain in order, so a load
// reaches each column before any later transform does and after any earlier
// one. Each cell is two stages (multiply, then shift and add), so a
// transform passes through both stages of all four cells and then the output
// register before its result appears. s_ready drops only while the output
// skid word is occupied, i.e. when the consumer has stalled for two
// results. Products are floored by FRAC_BITS, summed exactly and saturated
// to 32 bits. Matrix resets to identity; no clearing pass.
// ----------------------------------------------------------------------------
module mat4_vec4_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mvt_pkg::mvt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mvt_pkg::mvt_out_t m_data
);
    import mvt_pkg::*;

    mvt_word_t chain [NUM_LANES+1];
    logic      skid_full;
    logic      adv;

    // Whole chain advances whenever the skid word is free.
    assign adv     = !skid_full;
    assign s_ready = adv;

    assign chain[0].valid = s_valid;
    assign chain[0].item  = s_data;
    assign chain[0].sums  = '0;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_cell
        mvt_cell #(
            .FRAC_BITS (FRAC_BITS),
            .COL       (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_word  (chain[g]),
            .out_word (chain[g+1])
        );
    end

    mvt_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tail_word (chain[NUM_LANES]),
        .skid_full (skid_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Skid word in use implies a result is being shown.
    a_skid_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid occupied without a valid output word");

    // Skid only fills when the output word was stalled.
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("skid filled while output was free");

    // A transform leaving the chain always lands as a result.
    a_tail_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && chain[NUM_LANES].valid && chain[NUM_LANES].item.func == FUNC_XFORM)
        |=> m_valid)
        else $error("transform result dropped at chain tail");

endmodule

@@ tb/sv/mvt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_checker: scoreboard for the 4x4 matrix / 4-vector transform
// Watches both channels. Keeps a shadow copy of the matrix, computes M * v
// for every accepted transform word and compares each result word with the
// oldest outstanding one, lane by lane.
// ----------------------------------------------------------------------------
module mvt_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  mvt_pkg::mvt_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  mvt_pkg::mvt_out_t m_data,
    output int                err_count,
    output int                pending
);
    import mvt_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -(64'sd1 <<< 31);
    localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [DATA_W-1:0] shadow_mat [16];
    mvt_out_t                 pending_vertices [$];
    mvt_out_t                 head_vtx;

    // Floor each product by FRAC_BITS, sum exactly, clamp to 32 bits.
    function automatic mvt_out_t transform_vertex(input mvt_in_t w);
        logic signed [DATA_W-1:0] comp [NUM_LANES];
        logic signed [DATA_W-1:0] lane [NUM_LANES];
        longint                   acc;
        comp[0] = w.vec_x;
        comp[1] = w.vec_y;
        comp[2] = w.vec_z;
        comp[3] = w.vec_w;
        for (int r = 0; r < NUM_LANES; r++) begin
            acc = 0;
            for (int c = 0; c < NUM_LANES; c++) begin
                acc += (longint'(shadow_mat[c*NUM_LANES + r]) * longint'(comp[c]))
                       >>> FRAC_BITS;
            end
            if (acc > Q_MAX) begin
                lane[r] = Q_MAX[DATA_W-1:0];
            end else if (acc < Q_MIN) begin
                lane[r] = Q_MIN[DATA_W-1:0];
            end else begin
                lane[r] = acc[DATA_W-1:0];
            end
        end
        return '{out_x: lane[0], out_y: lane[1], out_z: lane[2], out_w: lane[3]};
    endfunction

    task automatic check_lane(input string name, input logic signed [DATA_W-1:0] exp_v,
                              input logic signed [DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                shadow_mat[i] = (i % 5 == 0) ? ONE : '0;
            end
            pending_vertices.delete();
            pending   = 0;
            err_count = 0;
        end else begin
            // results first: a word taken at this edge cannot leave at it
            if (m_valid && m_ready) begin
                if (pending_vertices.size() == 0) begin
                    $error("result word with no transform outstanding: %0d %0d %0d %0d",
                           m_data.out_x, m_data.out_y, m_data.out_z, m_data.out_w);
                    err_count++;
                end else begin
                    head_vtx = pending_vertices.pop_front();
                    check_lane("out_x", head_vtx.out_x, m_data.out_x);
                    check_lane("out_y", head_vtx.out_y, m_data.out_y);
                    check_lane("out_z", head_vtx.out_z, m_data.out_z);
                    check_lane("out_w", head_vtx.out_w, m_data.out_w);
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_LOAD) begin
                    shadow_mat[s_data.entry_index] = s_data.entry_value;
                end else begin
                    pending_vertices.push_back(transform_vertex(s_data));
                end
            end
            pending = pending_vertices.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the mat4_vec4_transform test
// Drives load and transform words under random backpressure on both sides,
// including a long output stall and a full drain, and reports the verdict
// from the scoreboard's error count.
// ----------------------------------------------------------------------------
module testbench;
    import mvt_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int HOLD_CYCLES     = 300;   // long output stall, fills the pipe
    localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES    = 20;    // pipeline latency plus margin

    localparam logic signed [DATA_W-1:0] ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mvt_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    mvt_out_t  m_data;

    int        err_count;
    int        pending_words;

    // Backpressure knobs, percent of cycles spent idle on each side.
    int        snd_idle_pct = 0;
    int        rcv_idle_pct = 0;

    // Long-stall requests: stimulus bumps hold_asks, receiver serves them.
    int        hold_asks    = 0;
    int        holds_served = 0;
    int        hold_left    = 0;

    int        stall_cycles = 0;

    mat4_vec4_transform #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mvt_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .err_count (err_count),
        .pending   (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------

    // Q16.16 operand: mostly tame so sums land in range, some full-scale
    // values and the corner codes so saturation gets hit too.
    function automatic logic signed [DATA_W-1:0] rand_q(input bit wild);
        logic signed [DATA_W-1:0] v;
        if (!wild) begin
            if ($urandom_range(1) == 0) begin
                v = $urandom_range(0, 32'h000FFFFF) - 32'h00080000;  // +/- 8.0
            end else begin
                v = $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;  // +/- 256.0
            end
        end else begin
            case ($urandom_range(7))
                0:       v = Q_MAX;
                1:       v = Q_MIN;
                2:       v = ONE;
                3:       v = -ONE;
                4:       v = (($urandom_range(1) == 0) ? 1 : -1);
                default: v = $urandom();
            endcase
        end
        return v;
    endfunction

    // Load word; vector lanes are don't-care, so fill them with noise.
    function automatic mvt_in_t mk_load(input logic [IDX_W-1:0] idx,
                                        input logic signed [DATA_W-1:0] val);
        mvt_in_t w;
        w.func        = FUNC_LOAD;
        w.entry_index = idx;
        w.entry_value = val;
        w.vec_x       = $urandom();
        w.vec_y       = $urandom();
        w.vec_z       = $urandom();
        w.vec_w       = $urandom();
        return w;
    endfunction

    // Transform word; entry fields are don't-care here.
    function automatic mvt_in_t mk_xform(input logic signed [DATA_W-1:0] x,
                                         input logic signed [DATA_W-1:0] y,
                                         input logic signed [DATA_W-1:0] z,
                                         input logic signed [DATA_W-1:0] wv);
        mvt_in_t w;
        w.func        = FUNC_XFORM;
        w.entry_index = IDX_W'($urandom_range(15));
        w.entry_value = $urandom();
        w.vec_x       = x;
        w.vec_y       = y;
        w.vec_z       = z;
        w.vec_w       = wv;
        return w;
    endfunction

    // Random mix: about 30% loads (mostly tame entries), rest transforms.
    function automatic mvt_in_t rand_word();
        mvt_in_t w;
        if ($urandom_range(99) < 30) begin
            w = mk_load(IDX_W'($urandom_range(15)), rand_q($urandom_range(99) < 15));
        end else begin
            w = mk_xform(rand_q($urandom_range(99) < 25), rand_q($urandom_range(99) < 25),
                         rand_q($urandom_range(99) < 25), rand_q($urandom_range(99) < 25));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender: entered and left at a falling edge. Optional idle gap, then
    // hold valid and the word until a rising edge sees ready.
    // ------------------------------------------------------------------
    task automatic push_word(input mvt_in_t w);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and sit until the scoreboard has seen every result.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_words != 0) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, or a counted long hold when one is asked for.
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left  = hold_left - 1;
            end else if (holds_served != hold_asks) begin
                holds_served = holds_served + 1;
                hold_left    = HOLD_CYCLES - 1;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake on either channel for too long ends the run.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        snd_idle_pct = 38;
        rcv_idle_pct = 49;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Matrix is identity out of reset.
        push_word(mk_xform(ONE, 2*ONE, 3*ONE, -4*ONE));
        push_word(mk_xform(Q_MAX, Q_MIN, 0, -1));

        // Row 0 all max: positive clamp on max vector, negative on min.
        for (int k = 0; k < 4; k++) push_word(mk_load(4'(k*4), Q_MAX));
        push_word(mk_xform(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        push_word(mk_xform(Q_MIN, Q_MIN, Q_MIN, Q_MIN));

        // Row 1 all min: min*min clamps high, min*max clamps low.
        for (int k = 0; k < 4; k++) push_word(mk_load(4'(k*4 + 1), Q_MIN));
        push_word(mk_xform(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        push_word(mk_xform(Q_MAX, Q_MAX, Q_MAX, Q_MAX));

        // Smallest entry in the corner: tiny negative product floors to -1 lsb.
        push_word(mk_load(4'd15, 1));
        push_word(mk_xform(0, 0, 0, -1));
        push_word(mk_xform(0, 0, 0, 1));

        // Negative unit on the diagonal.
        push_word(mk_load(4'd10, -ONE));
        push_word(mk_xform(ONE, -ONE, ONE + ONE/2, ONE));

        // Three random phases; each ends with a full drain.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 38;
                    rcv_idle_pct = 49;
                    hold_asks    = hold_asks + 1;  // stall output, keep offering
                end
                1: begin
                    snd_idle_pct = 49;
                    rcv_idle_pct = 38;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) push_word(rand_word());
            drain_results();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
